### rtl/bsa_pkg.sv
// bsa_pkg: sizes, register codes and fixed-point helpers of the bilinear splat accumulator
// used by every other file of the block except bsa_ram; depends on nothing

package bsa_pkg;

  localparam int unsigned MAX_COLS  = 256;
  localparam int unsigned MAX_ROWS  = 256;
  localparam int unsigned FRAC_BITS = 8;

  localparam int unsigned POS_W  = 18;
  localparam int unsigned VAL_W  = 24;
  localparam int unsigned RC_W   = 8;
  localparam int unsigned CNT_W  = 3;
  localparam int unsigned MEAN_W = 24;
  localparam int unsigned WSUM_W = 32;
  localparam int unsigned VSUM_W = 48;
  localparam int unsigned GRID_W = 9;

  localparam int unsigned CELLS  = MAX_COLS * MAX_ROWS;
  localparam int unsigned ADDR_W = $clog2(CELLS);

  localparam int unsigned ONE     = 1 << FRAC_BITS;
  localparam int unsigned FAC_W   = FRAC_BITS + 1;
  localparam int unsigned WGT_W   = 17;
  localparam int unsigned PROD_W  = VAL_W + WGT_W;
  localparam int unsigned COORD_W = POS_W - FRAC_BITS + 1;
  localparam int unsigned CMP_W   = (COORD_W > GRID_W) ? COORD_W : GRID_W;

  localparam int unsigned SH_R = (2 * FRAC_BITS >= 16) ? (2 * FRAC_BITS - 16) : 0;
  localparam int unsigned SH_L = (2 * FRAC_BITS < 16) ? (16 - 2 * FRAC_BITS) : 0;

  localparam int unsigned DIV_STEPS = VSUM_W;
  localparam int unsigned DIVC_W    = $clog2(DIV_STEPS);

  localparam int unsigned PADDR_W   = 3;
  localparam int unsigned PDATA_W   = 32;
  localparam logic [GRID_W-1:0] GRID_RESET = GRID_W'(256);

  localparam logic REG_GRID_COLS = 1'b0;
  localparam logic REG_GRID_ROWS = 1'b1;

  localparam logic ACT_SPLAT = 1'b0;
  localparam logic ACT_READ  = 1'b1;

  // bilinear product (2*FRAC_BITS fraction bits) to a Q.16 weight
  function automatic logic [WGT_W-1:0] to_q16(input logic [PROD_W-1:0] p);
    logic [PROD_W+16-1:0] t;
    t = ((PROD_W + 16)'(p) << SH_L) >> SH_R;
    return t[WGT_W-1:0];
  endfunction

endpackage

### rtl/bsa_if.sv
// bsa_if: input and result channel interfaces of the bilinear splat accumulator
// depends on bsa_pkg for field widths

interface bsa_in_if;
  logic                               valid;
  logic                               ready;
  logic                               action;
  logic signed [bsa_pkg::POS_W-1:0]   x_pos;
  logic signed [bsa_pkg::POS_W-1:0]   y_pos;
  logic        [bsa_pkg::VAL_W-1:0]   sample_value;
  logic        [bsa_pkg::RC_W-1:0]    read_col;
  logic        [bsa_pkg::RC_W-1:0]    read_row;

  modport source (
    output valid, action, x_pos, y_pos, sample_value, read_col, read_row,
    input  ready
  );
  modport sink (
    input  valid, action, x_pos, y_pos, sample_value, read_col, read_row,
    output ready
  );
endinterface

interface bsa_out_if;
  logic                          valid;
  logic                          ready;
  logic                          was_read;
  logic [bsa_pkg::CNT_W-1:0]     cells_written;
  logic [bsa_pkg::MEAN_W-1:0]    mean_value;
  logic [bsa_pkg::WSUM_W-1:0]    weight_total;
  logic                          saturated;

  modport source (
    output valid, was_read, cells_written, mean_value, weight_total, saturated,
    input  ready
  );
  modport sink (
    input  valid, was_read, cells_written, mean_value, weight_total, saturated,
    output ready
  );
endinterface

### rtl/bsa_ram.sv
// bsa_ram: generic single-port RAM with registered read
// no dependencies

module bsa_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    addr_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/bsa_div.sv
// bsa_div: restoring divider, one quotient bit per cycle, for the cell mean
// depends on bsa_pkg for operand widths and step count

module bsa_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [bsa_pkg::VSUM_W-1:0]  dividend_i,
  input  logic [bsa_pkg::WSUM_W-1:0]  divisor_i,
  output logic                        done_o,
  output logic [bsa_pkg::VSUM_W-1:0]  quot_o
);

  logic                        busy_q;
  logic                        done_q;
  logic [bsa_pkg::DIVC_W-1:0]  cnt_q;
  logic [bsa_pkg::WSUM_W-1:0]  rem_q;
  logic [bsa_pkg::WSUM_W-1:0]  dvs_q;
  logic [bsa_pkg::VSUM_W-1:0]  quo_q;

  logic [bsa_pkg::WSUM_W:0]    rem_sh;
  logic [bsa_pkg::WSUM_W:0]    rem_sub;
  logic                        q_bit;

  // shared compare and subtract
  always_comb begin
    rem_sh  = {rem_q, quo_q[bsa_pkg::VSUM_W-1]};
    rem_sub = rem_sh - {1'b0, dvs_q};
    q_bit   = (rem_sh >= {1'b0, dvs_q});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == bsa_pkg::DIVC_W'(bsa_pkg::DIV_STEPS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      dvs_q <= divisor_i;
      quo_q <= dividend_i;
    end else if (busy_q) begin
      rem_q <= q_bit ? rem_sub[bsa_pkg::WSUM_W-1:0] : rem_sh[bsa_pkg::WSUM_W-1:0];
      quo_q <= {quo_q[bsa_pkg::VSUM_W-2:0], q_bit};
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

### rtl/bilinear_splat_accumulator.sv
// bilinear_splat_accumulator: top level, sequencer, shared multiplier and cell stores
// depends on bsa_pkg, bsa_if, bsa_ram and bsa_div

// After reset the block sweeps both cell stores to zero, one cell per cycle, over all
// MAX_COLS*MAX_ROWS cells (65536 at the default size); in_chan_i.ready stays low
// until then, while grid register writes are taken at once. The block then handles
// one transaction at a time and is not ready while one is in work. A splat visits its
// four neighbor cells in turn through one shared multiplier and a read-modify-write
// of both single-port stores: each in-grid cell passes the weight, multiply and write
// states, while a cell off the grid is only passed over in the weight state. A read
// takes one store read and then the bit-serial divider, one quotient bit per cycle,
// or skips the divider when the cell weight is zero. The result sits in an output
// register, so the next transaction is accepted while the last result still waits.

module bilinear_splat_accumulator (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  bsa_in_if.sink                       in_chan_i,
  bsa_out_if.source                    out_chan_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [bsa_pkg::PADDR_W-1:0]  paddr,
  input  logic [bsa_pkg::PDATA_W-1:0]  pwdata,
  output logic [bsa_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready
);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_WGT   = 3'd2;
  localparam logic [2:0] ST_MUL   = 3'd3;
  localparam logic [2:0] ST_WR    = 3'd4;
  localparam logic [2:0] ST_RD    = 3'd5;
  localparam logic [2:0] ST_DIV   = 3'd6;
  localparam logic [2:0] ST_FIN   = 3'd7;

  logic [2:0] state_q, state_d;

  // configuration
  logic [bsa_pkg::GRID_W-1:0] grid_cols_q, grid_rows_q;
  logic [bsa_pkg::GRID_W-1:0] eff_cols, eff_rows;
  logic                       cfg_wr;

  assign cfg_wr = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_cols_q <= bsa_pkg::GRID_RESET;
      grid_rows_q <= bsa_pkg::GRID_RESET;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        bsa_pkg::REG_GRID_COLS: grid_cols_q <= pwdata[bsa_pkg::GRID_W-1:0];
        bsa_pkg::REG_GRID_ROWS: grid_rows_q <= pwdata[bsa_pkg::GRID_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      bsa_pkg::REG_GRID_COLS: prdata = bsa_pkg::PDATA_W'(grid_cols_q);
      bsa_pkg::REG_GRID_ROWS: prdata = bsa_pkg::PDATA_W'(grid_rows_q);
      default:                prdata = '0;
    endcase
  end

  assign eff_cols = (32'(grid_cols_q) < bsa_pkg::MAX_COLS) ? grid_cols_q
                                                          : bsa_pkg::GRID_W'(bsa_pkg::MAX_COLS);
  assign eff_rows = (32'(grid_rows_q) < bsa_pkg::MAX_ROWS) ? grid_rows_q
                                                          : bsa_pkg::GRID_W'(bsa_pkg::MAX_ROWS);

  // transaction registers
  logic                                 is_read_q;
  logic [bsa_pkg::VAL_W-1:0]            val_q;
  logic [bsa_pkg::FRAC_BITS-1:0]        fx_q, fy_q;
  logic signed [bsa_pkg::COORD_W-2:0]   x0_q, y0_q;
  logic [1:0]                           cell_q;
  logic [bsa_pkg::CNT_W-1:0]            cnt_q;
  logic                                 sat_q;
  logic                                 rd_ok_q;
  logic [bsa_pkg::ADDR_W-1:0]           addr_q;
  logic [bsa_pkg::PROD_W-1:0]           prod_q;
  logic [bsa_pkg::WGT_W-1:0]            w_q;
  logic [bsa_pkg::MEAN_W-1:0]           mean_q;
  logic [bsa_pkg::WSUM_W-1:0]           rw_q;
  logic [bsa_pkg::ADDR_W-1:0]           clr_q;

  // output register
  logic                           out_valid_q;
  logic                           out_was_read_q;
  logic [bsa_pkg::CNT_W-1:0]      out_cnt_q;
  logic [bsa_pkg::MEAN_W-1:0]     out_mean_q;
  logic [bsa_pkg::WSUM_W-1:0]     out_wt_q;
  logic                           out_sat_q;

  logic in_fire, out_fire, out_load;

  assign in_chan_i.ready = (state_q == ST_IDLE);
  assign in_fire         = in_chan_i.valid && in_chan_i.ready;
  assign out_fire        = out_valid_q && out_chan_o.ready;
  assign out_load        = (state_q == ST_FIN) && (!out_valid_q || out_chan_o.ready);

  // current neighbor cell
  logic                               dx, dy;
  logic signed [bsa_pkg::COORD_W-1:0] col_c, row_c;
  logic                               cell_ok;
  logic [bsa_pkg::FAC_W-1:0]          wx, wy;
  logic [bsa_pkg::ADDR_W-1:0]         cell_idx;

  always_comb begin
    dx    = cell_q[0];
    dy    = cell_q[1];
    col_c = bsa_pkg::COORD_W'(x0_q) + bsa_pkg::COORD_W'(dx);
    row_c = bsa_pkg::COORD_W'(y0_q) + bsa_pkg::COORD_W'(dy);
    cell_ok = !col_c[bsa_pkg::COORD_W-1] && !row_c[bsa_pkg::COORD_W-1]
           && (bsa_pkg::CMP_W'($unsigned(col_c)) < bsa_pkg::CMP_W'(eff_cols))
           && (bsa_pkg::CMP_W'($unsigned(row_c)) < bsa_pkg::CMP_W'(eff_rows));
    wx = dx ? bsa_pkg::FAC_W'(fx_q) : bsa_pkg::FAC_W'(bsa_pkg::ONE) - bsa_pkg::FAC_W'(fx_q);
    wy = dy ? bsa_pkg::FAC_W'(fy_q) : bsa_pkg::FAC_W'(bsa_pkg::ONE) - bsa_pkg::FAC_W'(fy_q);
    cell_idx = bsa_pkg::ADDR_W'($unsigned(row_c)) * bsa_pkg::ADDR_W'(bsa_pkg::MAX_COLS)
             + bsa_pkg::ADDR_W'($unsigned(col_c));
  end

  // read request
  logic                       rd_ok;
  logic [bsa_pkg::ADDR_W-1:0] rd_idx;

  assign rd_ok  = (32'(in_chan_i.read_col) < bsa_pkg::MAX_COLS)
               && (32'(in_chan_i.read_row) < bsa_pkg::MAX_ROWS);
  assign rd_idx = bsa_pkg::ADDR_W'(in_chan_i.read_row) * bsa_pkg::ADDR_W'(bsa_pkg::MAX_COLS)
                + bsa_pkg::ADDR_W'(in_chan_i.read_col);

  // shared multiplier
  logic [bsa_pkg::VAL_W-1:0]  mul_a;
  logic [bsa_pkg::WGT_W-1:0]  mul_b;
  logic [bsa_pkg::PROD_W-1:0] mul_p;
  logic [bsa_pkg::WGT_W-1:0]  wgt;

  assign wgt = bsa_pkg::to_q16(prod_q);

  always_comb begin
    case (state_q)
      ST_WGT: begin
        mul_a = bsa_pkg::VAL_W'(wx);
        mul_b = bsa_pkg::WGT_W'(wy);
      end
      ST_MUL: begin
        mul_a = val_q;
        mul_b = wgt;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    mul_p = bsa_pkg::PROD_W'(mul_a) * bsa_pkg::PROD_W'(mul_b);
  end

  // cell stores
  logic                        ram_we;
  logic [bsa_pkg::ADDR_W-1:0]  ram_addr;
  logic [bsa_pkg::VSUM_W-1:0]  v_wdata, v_rdata;
  logic [bsa_pkg::WSUM_W-1:0]  w_wdata, w_rdata;
  logic [bsa_pkg::VSUM_W:0]    v_sum;
  logic [bsa_pkg::WSUM_W:0]    w_sum;
  logic                        v_clip, w_clip;

  always_comb begin
    v_sum  = {1'b0, v_rdata} + (bsa_pkg::VSUM_W + 1)'(prod_q);
    w_sum  = {1'b0, w_rdata} + (bsa_pkg::WSUM_W + 1)'(w_q);
    v_clip = v_sum[bsa_pkg::VSUM_W];
    w_clip = w_sum[bsa_pkg::WSUM_W];
    case (state_q)
      ST_CLEAR: begin
        ram_we   = 1'b1;
        ram_addr = clr_q;
        v_wdata  = '0;
        w_wdata  = '0;
      end
      ST_IDLE: begin
        ram_we   = 1'b0;
        ram_addr = rd_idx;
        v_wdata  = '0;
        w_wdata  = '0;
      end
      ST_WR: begin
        ram_we   = 1'b1;
        ram_addr = addr_q;
        v_wdata  = v_clip ? '1 : v_sum[bsa_pkg::VSUM_W-1:0];
        w_wdata  = w_clip ? '1 : w_sum[bsa_pkg::WSUM_W-1:0];
      end
      default: begin
        ram_we   = 1'b0;
        ram_addr = addr_q;
        v_wdata  = '0;
        w_wdata  = '0;
      end
    endcase
  end

  bsa_ram #(
    .WIDTH (bsa_pkg::VSUM_W),
    .DEPTH (bsa_pkg::CELLS)
  ) u_vsum_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (v_wdata),
    .rdata_o (v_rdata)
  );

  bsa_ram #(
    .WIDTH (bsa_pkg::WSUM_W),
    .DEPTH (bsa_pkg::CELLS)
  ) u_wsum_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (w_wdata),
    .rdata_o (w_rdata)
  );

  // divider
  logic                        div_start, div_done;
  logic [bsa_pkg::VSUM_W-1:0]  div_quot;
  logic [bsa_pkg::MEAN_W-1:0]  div_mean;

  assign div_start = (state_q == ST_RD) && rd_ok_q && (w_rdata != '0);
  assign div_mean  = (|div_quot[bsa_pkg::VSUM_W-1:bsa_pkg::MEAN_W]) ? '1
                                                                   : div_quot[bsa_pkg::MEAN_W-1:0];

  bsa_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (v_rdata),
    .divisor_i  (w_rdata),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  // sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (clr_q == bsa_pkg::ADDR_W'(bsa_pkg::CELLS - 1)) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_fire) state_d = (in_chan_i.action == bsa_pkg::ACT_READ) ? ST_RD : ST_WGT;
      end
      ST_WGT: begin
        if (cell_ok) state_d = ST_MUL;
        else if (cell_q == 2'd3) state_d = ST_FIN;
      end
      ST_MUL: state_d = ST_WR;
      ST_WR:  state_d = (cell_q == 2'd3) ? ST_FIN : ST_WGT;
      ST_RD:  state_d = div_start ? ST_DIV : ST_FIN;
      ST_DIV: begin
        if (div_done) state_d = ST_FIN;
      end
      ST_FIN: begin
        if (out_load) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLEAR) clr_q <= clr_q + 1'b1;
      if (out_load) out_valid_q <= 1'b1;
      else if (out_fire) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          is_read_q <= (in_chan_i.action == bsa_pkg::ACT_READ);
          val_q     <= in_chan_i.sample_value;
          fx_q      <= in_chan_i.x_pos[bsa_pkg::FRAC_BITS-1:0];
          fy_q      <= in_chan_i.y_pos[bsa_pkg::FRAC_BITS-1:0];
          x0_q      <= in_chan_i.x_pos[bsa_pkg::POS_W-1:bsa_pkg::FRAC_BITS];
          y0_q      <= in_chan_i.y_pos[bsa_pkg::POS_W-1:bsa_pkg::FRAC_BITS];
          rd_ok_q   <= rd_ok;
          cell_q    <= 2'd0;
          cnt_q     <= '0;
          sat_q     <= 1'b0;
          mean_q    <= '0;
          rw_q      <= '0;
        end
      end
      ST_WGT: begin
        if (cell_ok) begin
          prod_q <= mul_p;
          addr_q <= cell_idx;
          cnt_q  <= cnt_q + 1'b1;
        end else begin
          cell_q <= cell_q + 1'b1;
        end
      end
      ST_MUL: begin
        w_q    <= wgt;
        prod_q <= mul_p;
      end
      ST_WR: begin
        sat_q  <= sat_q | v_clip | w_clip;
        cell_q <= cell_q + 1'b1;
      end
      ST_RD: begin
        rw_q <= rd_ok_q ? w_rdata : '0;
      end
      ST_DIV: begin
        if (div_done) mean_q <= div_mean;
      end
      default: ;
    endcase

    if (out_load) begin
      out_was_read_q <= is_read_q;
      out_cnt_q      <= cnt_q;
      out_mean_q     <= mean_q;
      out_wt_q       <= rw_q;
      out_sat_q      <= sat_q;
    end
  end

  assign out_chan_o.valid         = out_valid_q;
  assign out_chan_o.was_read      = out_was_read_q;
  assign out_chan_o.cells_written = out_cnt_q;
  assign out_chan_o.mean_value    = out_mean_q;
  assign out_chan_o.weight_total  = out_wt_q;
  assign out_chan_o.saturated     = out_sat_q;

endmodule
